### hw/rtl/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg: shared types and helpers of the condition text tokenizer
// Word formats, scanner modes, token kinds and character class functions.
// ----------------------------------------------------------------------------
package ctt_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
   localparam logic [15:0] LEN_MAX   = 16'hFFFF;

   localparam logic [3:0] KIND_END    = 4'd0;
   localparam logic [3:0] KIND_CONST  = 4'd1;
   localparam logic [3:0] KIND_IDENT  = 4'd2;
   localparam logic [3:0] KIND_IF     = 4'd3;
   localparam logic [3:0] KIND_AND    = 4'd4;
   localparam logic [3:0] KIND_OR     = 4'd5;
   localparam logic [3:0] KIND_GE     = 4'd6;
   localparam logic [3:0] KIND_LE     = 4'd7;
   localparam logic [3:0] KIND_EQ     = 4'd8;
   localparam logic [3:0] KIND_SINGLE = 4'd9;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_GT      = 8'h3E;
   localparam logic [7:0] CHAR_LT      = 8'h3C;
   localparam logic [7:0] CHAR_EQ      = 8'h3D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;

   localparam logic [23:0] PREFIX_IF  = 24'h00_69_66;
   localparam logic [23:0] PREFIX_AND = 24'h61_6E_64;
   localparam logic [23:0] PREFIX_OR  = 24'h00_6F_72;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_NUM   = 3'd1,
      MODE_IDENT = 3'd2,
      MODE_GT    = 3'd3,
      MODE_LT    = 3'd4,
      MODE_EQ    = 3'd5
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [7:0]  token_char;
      logic [30:0] int_value;
      logic        value_saturated;
      logic        has_percent;
      logic [15:0] token_length;
      logic        last_of_run;
   } rsp_type;

   // Tokens produced by one accepted word, handed from scanner to queue.
   typedef struct packed {
      logic [1:0] num;
      rsp_type    first;
      rsp_type    second;
   } tok_push_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
             || (c == 8'h5F);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'h20) : c;
   endfunction

   function automatic logic [15:0] inc_len(input logic [15:0] l);
      return (l == LEN_MAX) ? l : (l + 16'd1);
   endfunction

endpackage

### hw/rtl/condition_text_tokenizer.sv
// ----------------------------------------------------------------------------
// condition_text_tokenizer: streaming scanner for condition text
// Turns characters into tokens, one character word per cycle while not stalled.
// ----------------------------------------------------------------------------
// The req channel carries one word per character: char_code, or end_of_text
// to close the text. The rsp channel carries the tokens, each with its kind,
// the character of a single-character token, the value of a constant with its
// saturation and percent flags, its length in characters, and last_of_run on
// the final token caused by one request word.
// A request word is taken every cycle while req_stall is low, so a text is
// scanned at one character per clock. A word yields zero, one or two tokens.
// The scanner writes each token that an accepted word completes into a
// four-entry token queue, and the output register loads it from the queue
// head. The output register drains the queue at one token per cycle while
// rsp_stall is low; req_stall rises while fewer than two queue entries are
// free, so a stalled receiver backs up into the queue first and then holds
// off the sender. Tokens are never dropped or duplicated while rsp_stall is
// high; rsp_data is frozen.
// Reset clears the scanner to its idle state, empties the queue and drops
// rsp_valid. No clearing pass is needed; words are taken right after reset.
module condition_text_tokenizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ctt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ctt_pkg::rsp_type rsp_data
);

   ctt_pkg::tok_push_type push;
   ctt_pkg::rsp_type      head;
   logic                  queue_full;
   logic                  head_valid;
   logic                  pop;
   logic                  accept;

   // A word is taken only when the queue can hold everything it may produce.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Front end: scanner state and token formation.
   ctt_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push)
   );

   // Decoupling queue between front end and output.
   ctt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (head_valid),
      .head      (head)
   );

   // Back end: registered result port.
   ctt_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

### hw/rtl/ctt_scan.sv
// ----------------------------------------------------------------------------
// ctt_scan: front end of the tokenizer
// Holds the scanner state and turns each accepted word into zero to two tokens.
// ----------------------------------------------------------------------------
module ctt_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  ctt_pkg::req_type      req_data,
   output ctt_pkg::tok_push_type push
);

   ctt_pkg::scan_mode_type mode_ff, mode_in;
   logic [30:0] acc_ff, acc_in;
   logic        sat_ff, sat_in;
   logic [15:0] len_ff, len_in;
   logic [23:0] prefix_ff, prefix_in;

   logic [7:0]  c;
   logic        eot;
   logic [3:0]  digit;
   logic [34:0] acc_next_wide;
   logic        acc_over;
   logic [30:0] acc_step;
   logic        pair_mode;
   logic        consumed;

   ctt_pkg::rsp_type pend_tok, a_tok, b_tok, blank_tok;
   logic             pend_valid, a_valid, b_valid;
   logic [3:0]       ident_kind;

   assign c     = req_data.char_code;
   assign eot   = req_data.end_of_text;
   assign digit = c[3:0] - ctt_pkg::CHAR_ZERO[3:0];

   // value * 10 + digit by shift and add
   assign acc_next_wide = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                          + {31'd0, digit};
   assign acc_over      = acc_next_wide > {4'd0, ctt_pkg::VALUE_MAX};
   assign acc_step      = acc_over ? ctt_pkg::VALUE_MAX : acc_next_wide[30:0];

   assign pair_mode = (mode_ff == ctt_pkg::MODE_GT) || (mode_ff == ctt_pkg::MODE_LT)
                      || (mode_ff == ctt_pkg::MODE_EQ);

   always_comb begin
      consumed = 1'b0;
      if (!eot) begin
         case (mode_ff)
            ctt_pkg::MODE_NUM:   consumed = ctt_pkg::is_digit(c) || (c == ctt_pkg::CHAR_PERCENT);
            ctt_pkg::MODE_IDENT: consumed = ctt_pkg::is_alpha(c) || ctt_pkg::is_digit(c);
            ctt_pkg::MODE_GT,
            ctt_pkg::MODE_LT,
            ctt_pkg::MODE_EQ:    consumed = (c == ctt_pkg::CHAR_EQ);
            default:             consumed = 1'b0;
         endcase
      end
   end

   // Next scanner mode.
   always_comb begin
      mode_in = mode_ff;
      if (eot) begin
         mode_in = ctt_pkg::MODE_IDLE;
      end else if (consumed) begin
         if (mode_ff != ctt_pkg::MODE_NUM && mode_ff != ctt_pkg::MODE_IDENT) begin
            mode_in = ctt_pkg::MODE_IDLE;
         end else if (mode_ff == ctt_pkg::MODE_NUM && c == ctt_pkg::CHAR_PERCENT) begin
            mode_in = ctt_pkg::MODE_IDLE;
         end
      end else if (ctt_pkg::is_digit(c)) begin
         mode_in = ctt_pkg::MODE_NUM;
      end else if (ctt_pkg::is_alpha(c)) begin
         mode_in = ctt_pkg::MODE_IDENT;
      end else if (c == ctt_pkg::CHAR_GT) begin
         mode_in = ctt_pkg::MODE_GT;
      end else if (c == ctt_pkg::CHAR_LT) begin
         mode_in = ctt_pkg::MODE_LT;
      end else if (c == ctt_pkg::CHAR_EQ) begin
         mode_in = ctt_pkg::MODE_EQ;
      end else begin
         mode_in = ctt_pkg::MODE_IDLE;
      end
   end

   always_comb begin
      ident_kind = ctt_pkg::KIND_IDENT;
      if (len_ff == 16'd2 && prefix_ff == ctt_pkg::PREFIX_IF) begin
         ident_kind = ctt_pkg::KIND_IF;
      end else if (len_ff == 16'd3 && prefix_ff == ctt_pkg::PREFIX_AND) begin
         ident_kind = ctt_pkg::KIND_AND;
      end else if (len_ff == 16'd2 && prefix_ff == ctt_pkg::PREFIX_OR) begin
         ident_kind = ctt_pkg::KIND_OR;
      end
   end

   // Data path and emitted tokens.
   always_comb begin
      blank_tok  = '0;
      pend_tok   = blank_tok;
      pend_valid = 1'b0;
      case (mode_ff)
         ctt_pkg::MODE_NUM: begin
            pend_valid               = 1'b1;
            pend_tok.token_kind      = ctt_pkg::KIND_CONST;
            pend_tok.int_value       = acc_ff;
            pend_tok.value_saturated = sat_ff;
            pend_tok.token_length    = len_ff;
         end
         ctt_pkg::MODE_IDENT: begin
            pend_valid            = 1'b1;
            pend_tok.token_kind   = ident_kind;
            pend_tok.token_length = len_ff;
         end
         ctt_pkg::MODE_GT: begin
            pend_valid            = 1'b1;
            pend_tok.token_kind   = ctt_pkg::KIND_SINGLE;
            pend_tok.token_char   = ctt_pkg::CHAR_GT;
            pend_tok.token_length = 16'd1;
         end
         ctt_pkg::MODE_LT: begin
            pend_valid            = 1'b1;
            pend_tok.token_kind   = ctt_pkg::KIND_SINGLE;
            pend_tok.token_char   = ctt_pkg::CHAR_LT;
            pend_tok.token_length = 16'd1;
         end
         ctt_pkg::MODE_EQ: begin
            pend_valid            = 1'b1;
            pend_tok.token_kind   = ctt_pkg::KIND_SINGLE;
            pend_tok.token_char   = ctt_pkg::CHAR_EQ;
            pend_tok.token_length = 16'd1;
         end
         default: begin
            pend_valid = 1'b0;
         end
      endcase

      a_tok     = pend_tok;
      a_valid   = 1'b0;
      b_tok     = blank_tok;
      b_valid   = 1'b0;
      acc_in    = '0;
      sat_in    = 1'b0;
      len_in    = '0;
      prefix_in = '0;

      if (eot) begin
         a_valid          = pend_valid;
         b_valid          = 1'b1;
         b_tok.token_kind = ctt_pkg::KIND_END;
      end else if (consumed) begin
         if (mode_ff == ctt_pkg::MODE_NUM) begin
            if (ctt_pkg::is_digit(c)) begin
               acc_in    = acc_step;
               sat_in    = sat_ff | acc_over;
               len_in    = ctt_pkg::inc_len(len_ff);
               prefix_in = prefix_ff;
            end else begin
               a_valid              = 1'b1;
               a_tok.has_percent    = 1'b1;
               a_tok.token_length   = ctt_pkg::inc_len(len_ff);
            end
         end else if (mode_ff == ctt_pkg::MODE_IDENT) begin
            acc_in    = acc_ff;
            sat_in    = sat_ff;
            len_in    = ctt_pkg::inc_len(len_ff);
            prefix_in = (len_ff < 16'd3) ? {prefix_ff[15:0], ctt_pkg::to_lower(c)}
                                         : prefix_ff;
         end else if (pair_mode) begin
            a_valid            = 1'b1;
            a_tok              = blank_tok;
            a_tok.token_length = 16'd2;
            case (mode_ff)
               ctt_pkg::MODE_GT: a_tok.token_kind = ctt_pkg::KIND_GE;
               ctt_pkg::MODE_LT: a_tok.token_kind = ctt_pkg::KIND_LE;
               default:          a_tok.token_kind = ctt_pkg::KIND_EQ;
            endcase
         end
      end else begin
         // The pending token ends here and this character starts afresh.
         a_valid = pend_valid;
         if (ctt_pkg::is_digit(c)) begin
            acc_in = {27'd0, digit};
            len_in = 16'd1;
         end else if (ctt_pkg::is_alpha(c)) begin
            len_in    = 16'd1;
            prefix_in = {16'd0, ctt_pkg::to_lower(c)};
         end else if (!ctt_pkg::is_space(c) && c != ctt_pkg::CHAR_GT
                      && c != ctt_pkg::CHAR_LT && c != ctt_pkg::CHAR_EQ) begin
            b_valid            = 1'b1;
            b_tok.token_kind   = ctt_pkg::KIND_SINGLE;
            b_tok.token_char   = c;
            b_tok.token_length = 16'd1;
         end
      end

      push        = '0;
      push.first  = a_valid ? a_tok : b_tok;
      push.second = b_tok;
      if (accept) begin
         push.num = {1'b0, a_valid} + {1'b0, b_valid};
      end
      if (a_valid && b_valid) begin
         push.second.last_of_run = 1'b1;
      end else begin
         push.first.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ctt_pkg::MODE_IDLE;
         acc_ff    <= '0;
         sat_ff    <= 1'b0;
         len_ff    <= '0;
         prefix_ff <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         sat_ff    <= sat_in;
         len_ff    <= len_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule

### hw/rtl/ctt_queue.sv
// ----------------------------------------------------------------------------
// ctt_queue: token queue between scanner and output stage
// Takes up to two tokens per cycle and gives out one when popped.
// ----------------------------------------------------------------------------
module ctt_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  ctt_pkg::tok_push_type push,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output ctt_pkg::rsp_type      head
);

   ctt_pkg::rsp_type mem [ctt_pkg::QUEUE_DEPTH];

   logic [ctt_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ctt_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ctt_pkg::QUEUE_AW-1:0] wr_ptr_second;
   logic [ctt_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic                         do_pop;

   // Room for two more tokens is required before a word is taken.
   assign full      = count_ff > (ctt_pkg::QUEUE_AW + 1)'(ctt_pkg::QUEUE_DEPTH - 2);
   assign not_empty = count_ff != '0;
   assign head      = mem[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   // The second token of a word goes into the entry after the first one.
   assign wr_ptr_second = wr_ptr_ff + {{(ctt_pkg::QUEUE_AW-1){1'b0}}, 1'b1};

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.num[ctt_pkg::QUEUE_AW-1:0];
      rd_ptr_in = rd_ptr_ff + {{(ctt_pkg::QUEUE_AW-1){1'b0}}, do_pop};
      count_in  = count_ff + {{(ctt_pkg::QUEUE_AW-1){1'b0}}, push.num}
                  - {{ctt_pkg::QUEUE_AW{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         mem[wr_ptr_second] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/ctt_out_stage.sv
// ----------------------------------------------------------------------------
// ctt_out_stage: registered result port
// Loads the queue head whenever the result register is empty or being taken.
// ----------------------------------------------------------------------------
module ctt_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  ctt_pkg::rsp_type head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ctt_pkg::rsp_type rsp_data
);

   logic             valid_ff, valid_in;
   ctt_pkg::rsp_type data_ff;
   logic             load;

   assign load     = !valid_ff || !rsp_stall;
   assign pop      = load && head_valid;
   assign valid_in = load ? head_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= head;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
